[src/b90gd_pkg.sv]
// Shared types and constants for the base-90 grid decompressor.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package b90gd_pkg;

   // Character codes
   localparam logic [7:0] CHAR_TAB      = 8'd9;
   localparam logic [7:0] CHAR_CR       = 8'd13;
   localparam logic [7:0] CHAR_SPACE    = 8'd32;
   localparam logic [7:0] CHAR_BANG     = 8'd33;
   localparam logic [7:0] CHAR_QUOTE    = 8'd34;
   localparam logic [7:0] DIGIT_BASE    = 8'd37;
   localparam logic [7:0] DIGIT_TOP     = 8'd126;

   // Decode phases
   localparam logic [1:0] PH_NORMAL     = 2'd0;
   localparam logic [1:0] PH_COUNT      = 2'd1;
   localparam logic [1:0] PH_VALUE      = 2'd2;

   // Configuration register indexes
   localparam int         CSR_IDX_W     = 2;
   localparam logic [1:0] REG_DIGITS    = 2'd0;
   localparam logic [1:0] REG_SCALE     = 2'd1;
   localparam logic [1:0] REG_OFFSET    = 2'd2;
   localparam logic [1:0] REG_DUMMY     = 2'd3;

   localparam int         CSR_DATA_W    = 48;

   // Reset values of the configuration registers
   localparam logic [2:0]  RST_DIGITS   = 3'd1;
   localparam logic [23:0] RST_SCALE    = 24'h010000;
   localparam logic [47:0] RST_OFFSET   = 48'h0;
   localparam logic [31:0] RST_DUMMY    = 32'hFFFF_D8F1;

   typedef struct packed {
      logic decode;     // process the accepted byte
      logic mul;        // raw times scale into the product register
      logic add_load;   // add offset and load the output word
   } b90gd_cmd_type;

   typedef struct packed {
      logic val_close;   // current byte closes a group that needs scaling
      logic out_blocked; // output word held and stalled
   } b90gd_sts_type;

endpackage

`default_nettype wire

[src/base90_grid_decompressor.sv]
// Base-90 grid decompressor: takes one byte of compressed grid text per word on
// the req_ channel and delivers decoded grid words on the rsp_ channel. Whitespace
// is skipped; each group of digits_per_value base-90 characters (codes 37..126,
// most significant first) becomes raw * scale_factor + value_offset in Q48.16.
// An all-'!' group gives dummy_value << 16 with rsp_is_dummy set; an all-'"'
// group starts a repeat: the next group is an unscaled run count and the group
// after it is the value that carries that run length. Any other byte, or a mix
// of special and ordinary characters in one group, gives a word with
// rsp_bad_char set, value and run length zero, and drops any pending repeat.
// Timing: a byte that is whitespace, that adds to an open group, or that closes
// a count, dummy or error group is done in its decode step. A byte that closes
// a group needing scaling takes three steps: decode, the 34x24 multiply into a
// product register, then the offset add into the output register; req_stall is
// high during the multiply and add steps. The output register holds one word;
// while it is held and stalled the input is stalled too, otherwise a new byte is
// taken in the same cycle the previous word leaves. Configuration writes are
// taken at any time but should only be issued while the block is idle.
// Depends on b90gd_pkg, b90gd_ctrl and b90gd_dp.
`default_nettype none

module base90_grid_decompressor
   import b90gd_pkg::*;
#(
   parameter int MAX_DIGITS = 5
)(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // byte input channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_char_code,

   // decoded word channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [63:0]         rsp_grid_value,
   output logic [32:0]                rsp_run_length,
   output logic                       rsp_is_dummy,
   output logic                       rsp_bad_char,

   // configuration write port
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   b90gd_cmd_type cmd;
   b90gd_sts_type sts;

   // sequence: accept and decode, then multiply and add for scaled values
   b90gd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold config, group state, multiplier and output word
   b90gd_dp #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_char_code  (req_char_code),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grid_value (rsp_grid_value),
      .rsp_run_length (rsp_run_length),
      .rsp_is_dummy   (rsp_is_dummy),
      .rsp_bad_char   (rsp_bad_char)
   );

endmodule

`default_nettype wire

[src/b90gd_ctrl.sv]
// Controller for the base-90 grid decompressor: sequences decode, multiply, add.
// Depends on b90gd_pkg.
`default_nettype none

module b90gd_ctrl
   import b90gd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  b90gd_sts_type      sts,
   output b90gd_cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       req_fire;

   assign req_stall = (state_ff != ST_IDLE) || sts.out_blocked;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.decode   = 1'b0;
      cmd.mul      = 1'b0;
      cmd.add_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.decode = req_fire;
            if (req_fire && sts.val_close) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while a value is in the multiplier");

   a_mul_then_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_ADD))
      else $error("multiply step not followed by offset add");

   a_close_enters_mul: assert property (@(posedge clock) disable iff (reset)
      (cmd.decode && sts.val_close) |=> (state_ff == ST_MUL))
      else $error("value group closed without starting the multiply");

endmodule

`default_nettype wire

[src/b90gd_dp.sv]
// Datapath for the base-90 grid decompressor: config registers, group
// accumulator, repeat tracking, scaling multiplier and output word register.
// Depends on b90gd_pkg.
`default_nettype none

module b90gd_dp
   import b90gd_pkg::*;
#(
   parameter int MAX_DIGITS = 5
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  b90gd_cmd_type              cmd,
   output b90gd_sts_type              sts,
   input  wire logic [7:0]            req_char_code,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [63:0]         rsp_grid_value,
   output logic [32:0]                rsp_run_length,
   output logic                       rsp_is_dummy,
   output logic                       rsp_bad_char
);

   localparam logic [2:0] MaxWidth = 3'(MAX_DIGITS);

   // configuration
   logic [2:0]  digits_ff;
   logic [23:0] scale_ff;
   logic [47:0] offset_ff;
   logic [31:0] dummy_ff;

   // group and repeat state
   logic [2:0]  count_ff,   count_in;
   logic [32:0] acc_ff,     acc_in;
   logic [1:0]  phase_ff,   phase_in;
   logic [32:0] pending_ff, pending_in;
   logic        bang_ff,    bang_in;
   logic        quote_ff,   quote_in;

   // multiply stage
   logic [32:0]        mraw_ff;
   logic [32:0]        mrun_ff;
   logic signed [57:0] prod_ff;

   // output word
   logic               out_valid_ff;
   logic signed [63:0] out_grid_ff;
   logic [32:0]        out_run_ff;
   logic               out_dummy_ff;
   logic               out_bad_ff;

   // byte classification and step results
   logic        is_ws, is_bang, is_quote, is_digit;
   logic [2:0]  width_eff;
   logic [32:0] acc_x90, acc_step;
   logic [2:0]  count_step;
   logic        bang_step, quote_step, abort, closes;
   logic        emit_now, emit_dummy, emit_bad, start_mul;
   logic [32:0] emit_run;
   logic [7:0]  digit;
   logic signed [63:0] dummy_q, value_q;

   assign is_ws    = (req_char_code == CHAR_SPACE) ||
                     (req_char_code >= CHAR_TAB && req_char_code <= CHAR_CR);
   assign is_bang  = (req_char_code == CHAR_BANG);
   assign is_quote = (req_char_code == CHAR_QUOTE);
   assign is_digit = (req_char_code >= DIGIT_BASE) && (req_char_code <= DIGIT_TOP);
   assign digit    = req_char_code - DIGIT_BASE;

   always_comb begin
      if (digits_ff == 3'd0)          width_eff = 3'd1;
      else if (digits_ff > MaxWidth)  width_eff = MaxWidth;
      else                            width_eff = digits_ff;
   end

   // times 90 as 64 + 16 + 8 + 2, kept to 33 bits
   assign acc_x90 = (acc_ff << 6) + (acc_ff << 4) + (acc_ff << 3) + (acc_ff << 1);

   always_comb begin
      abort      = 1'b0;
      bang_step  = bang_ff;
      quote_step = quote_ff;
      acc_step   = acc_x90;
      if (is_bang) begin
         abort      = (count_ff != 3'd0) && !bang_ff;
         quote_step = 1'b0;
      end else if (is_quote) begin
         abort      = (count_ff != 3'd0) && !quote_ff;
         bang_step  = 1'b0;
      end else if (is_digit) begin
         abort      = (count_ff != 3'd0) && (bang_ff || quote_ff);
         bang_step  = 1'b0;
         quote_step = 1'b0;
         acc_step   = acc_x90 + 33'(digit);
      end else if (!is_ws) begin
         abort = 1'b1;
      end
      count_step = count_ff + 3'd1;
      closes     = !is_ws && !abort && (count_step >= width_eff);
   end

   // group close handling per phase
   always_comb begin
      count_in   = count_ff;
      acc_in     = acc_ff;
      bang_in    = bang_ff;
      quote_in   = quote_ff;
      phase_in   = phase_ff;
      pending_in = pending_ff;
      emit_now   = 1'b0;
      emit_dummy = 1'b0;
      emit_bad   = 1'b0;
      emit_run   = 33'd1;
      start_mul  = 1'b0;
      if (!is_ws) begin
         count_in = count_step;
         acc_in   = acc_step;
         bang_in  = bang_step;
         quote_in = quote_step;
         if (abort || closes) begin
            count_in = 3'd0;
            acc_in   = 33'd0;
            bang_in  = 1'b1;
            quote_in = 1'b1;
         end
         if (abort) begin
            phase_in   = PH_NORMAL;
            pending_in = 33'd0;
            emit_now   = 1'b1;
            emit_bad   = 1'b1;
            emit_run   = 33'd0;
         end else if (closes) begin
            unique case (phase_ff)
               PH_COUNT: begin
                  if (bang_step || quote_step) begin
                     phase_in   = PH_NORMAL;
                     pending_in = 33'd0;
                     emit_now   = 1'b1;
                     emit_bad   = 1'b1;
                     emit_run   = 33'd0;
                  end else begin
                     pending_in = acc_step;
                     phase_in   = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  phase_in   = PH_NORMAL;
                  pending_in = 33'd0;
                  if (quote_step) begin
                     emit_now = 1'b1;
                     emit_bad = 1'b1;
                     emit_run = 33'd0;
                  end else if (bang_step) begin
                     emit_now   = 1'b1;
                     emit_dummy = 1'b1;
                     emit_run   = pending_ff;
                  end else begin
                     start_mul = 1'b1;
                     emit_run  = pending_ff;
                  end
               end
               default: begin
                  phase_in = PH_NORMAL;
                  if (bang_step) begin
                     emit_now   = 1'b1;
                     emit_dummy = 1'b1;
                  end else if (quote_step) begin
                     phase_in = PH_COUNT;
                  end else begin
                     start_mul = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   assign sts.val_close   = start_mul;
   assign sts.out_blocked = out_valid_ff && rsp_stall;

   assign dummy_q = {{16{dummy_ff[31]}}, dummy_ff, 16'h0000};
   assign value_q = {{6{prod_ff[57]}}, prod_ff} + {{16{offset_ff[47]}}, offset_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= RST_DIGITS;
         scale_ff  <= RST_SCALE;
         offset_ff <= RST_OFFSET;
         dummy_ff  <= RST_DUMMY;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIGITS: digits_ff <= csr_wr_data[2:0];
            REG_SCALE:  scale_ff  <= csr_wr_data[23:0];
            REG_OFFSET: offset_ff <= csr_wr_data[47:0];
            REG_DUMMY:  dummy_ff  <= csr_wr_data[31:0];
            default:    digits_ff <= digits_ff;
         endcase
      end
   end

   // group state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= 3'd0;
         acc_ff     <= 33'd0;
         phase_ff   <= PH_NORMAL;
         pending_ff <= 33'd0;
         bang_ff    <= 1'b1;
         quote_ff   <= 1'b1;
      end else if (cmd.decode) begin
         count_ff   <= count_in;
         acc_ff     <= acc_in;
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         bang_ff    <= bang_in;
         quote_ff   <= quote_in;
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (cmd.decode && start_mul) begin
         mraw_ff <= acc_step;
         mrun_ff <= emit_run;
      end
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, mraw_ff}) * $signed(scale_ff);
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((cmd.decode && emit_now) || cmd.add_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_load) begin
         out_grid_ff  <= value_q;
         out_run_ff   <= mrun_ff;
         out_dummy_ff <= 1'b0;
         out_bad_ff   <= 1'b0;
      end else if (cmd.decode && emit_now) begin
         out_grid_ff  <= emit_dummy ? dummy_q : 64'sd0;
         out_run_ff   <= emit_run;
         out_dummy_ff <= emit_dummy;
         out_bad_ff   <= emit_bad;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_grid_value = out_grid_ff;
   assign rsp_run_length = out_run_ff;
   assign rsp_is_dummy   = out_dummy_ff;
   assign rsp_bad_char   = out_bad_ff;

   a_load_into_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.add_load |-> !out_valid_ff)
      else $error("scaled value would overwrite an undelivered word");

   a_bad_word_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_bad_ff) |-> (!out_dummy_ff && out_run_ff == 33'd0))
      else $error("error word carries dummy flag or run length");

endmodule

`default_nettype wire

[tb/base90_grid_decompressor_test.sv]
// Self-checking bench for the base-90 grid decompressor: streams grid text bytes,
// predicts every decoded word and compares the rsp_ channel against it.
// Depends on b90gd_pkg and base90_grid_decompressor.
`timescale 1ns / 1ps

module base90_grid_decompressor_test
   import b90gd_pkg::*;
();

   localparam int MAX_DIGITS = 5;
   localparam int SETTLE_CYCLES = 8;   // a byte without a word is done well within this

   typedef struct {
      logic [63:0] value;
      logic [32:0] run;
      logic        dummy;
      logic        bad;
   } grid_word_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_char_code;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [63:0]    rsp_grid_value;
   logic [32:0]           rsp_run_length;
   logic                  rsp_is_dummy;
   logic                  rsp_bad_char;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   base90_grid_decompressor #(.MAX_DIGITS(MAX_DIGITS)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grid_value (rsp_grid_value),
      .rsp_run_length (rsp_run_length),
      .rsp_is_dummy   (rsp_is_dummy),
      .rsp_bad_char   (rsp_bad_char),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   // Bench copy of the configuration registers
   logic [2:0]         digits_cfg;
   logic signed [23:0] scale_cfg;
   logic signed [47:0] offset_cfg;
   logic signed [31:0] dummy_cfg;

   // Bench copy of the decoder state
   logic [2:0]  group_len;
   logic [32:0] group_acc;
   logic        only_bang;
   logic        only_quote;
   logic [1:0]  repeat_phase;
   logic [32:0] repeat_count;

   logic [7:0]     text_bytes[$];      // bytes still to be offered on req_
   grid_word_type  expected_words[$];  // decoded words owed by the block

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int          fault_count;
   int          bytes_queued;

   // ---------------------------------------------------------------------------
   // Clock and time limit
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Allow far more time than the slowest correct run needs.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Decoder prediction
   // ---------------------------------------------------------------------------
   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // Group width as the block sees it: zero acts as one, large values clamp.
   function automatic int group_width();
      if (digits_cfg == 3'd0) return 1;
      if (digits_cfg > MAX_DIGITS) return MAX_DIGITS;
      return int'(digits_cfg);
   endfunction

   function automatic void clear_group();
      group_len  = '0;
      group_acc  = '0;
      only_bang  = 1'b1;
      only_quote = 1'b1;
   endfunction

   function automatic void owe_word(input logic [63:0] value, input logic [32:0] run,
                                    input logic dummy, input logic bad);
      grid_word_type w;
      w.value = value;
      w.run   = run;
      w.dummy = dummy;
      w.bad   = bad;
      expected_words.push_back(w);
   endfunction

   // Drop the group and any pending repeat; owe an error word.
   function automatic void abort_group();
      clear_group();
      repeat_phase = PH_NORMAL;
      repeat_count = '0;
      owe_word('0, '0, 1'b0, 1'b1);
   endfunction

   function automatic logic [63:0] scaled(input logic [32:0] raw);
      return longint'(raw) * longint'(scale_cfg) + longint'(offset_cfg);
   endfunction

   function automatic logic [63:0] dummy_word();
      return longint'(dummy_cfg) * 64'sd65536;
   endfunction

   function automatic void decode_byte(input logic [7:0] c);
      logic [32:0] raw;
      logic        bang;
      logic        quote;
      logic [32:0] run;
      if (is_space(c)) return;
      if (c == CHAR_BANG) begin
         if (group_len != 0 && !only_bang) begin
            abort_group();
            return;
         end
         only_quote = 1'b0;
         group_acc  = group_acc * 33'd90;
      end else if (c == CHAR_QUOTE) begin
         if (group_len != 0 && !only_quote) begin
            abort_group();
            return;
         end
         only_bang = 1'b0;
         group_acc = group_acc * 33'd90;
      end else if (c >= DIGIT_BASE && c <= DIGIT_TOP) begin
         if (group_len != 0 && (only_bang || only_quote)) begin
            abort_group();
            return;
         end
         only_bang  = 1'b0;
         only_quote = 1'b0;
         group_acc  = group_acc * 33'd90 + 33'(c - DIGIT_BASE);
      end else begin
         abort_group();
         return;
      end

      group_len = group_len + 3'd1;
      if (int'(group_len) < group_width()) return;

      raw   = group_acc;
      bang  = only_bang;
      quote = only_quote;
      clear_group();

      case (repeat_phase)
         PH_COUNT: begin
            // a special code cannot stand as a run count
            if (bang || quote) begin
               abort_group();
            end else begin
               repeat_count = raw;
               repeat_phase = PH_VALUE;
            end
         end
         PH_VALUE: begin
            run = repeat_count;
            if (quote) begin
               abort_group();
            end else begin
               repeat_phase = PH_NORMAL;
               repeat_count = '0;
               if (bang) owe_word(dummy_word(), run, 1'b1, 1'b0);
               else owe_word(scaled(raw), run, 1'b0, 1'b0);
            end
         end
         default: begin
            repeat_phase = PH_NORMAL;
            if (bang) owe_word(dummy_word(), 33'd1, 1'b1, 1'b0);
            else if (quote) repeat_phase = PH_COUNT;
            else owe_word(scaled(raw), 33'd1, 1'b0, 1'b0);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: offer queued bytes, idling at random; hold a stalled byte.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_char_code <= text_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: check each word that leaves, predict from each byte that enters,
   // and stall the result channel at random.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      grid_word_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // check before predicting: a word leaving now never stems from a byte
         // entering now
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected word: value %h run %h dummy %b bad %b",
                           rsp_grid_value, rsp_run_length, rsp_is_dummy, rsp_bad_char);
               fault_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_grid_value !== w.value || rsp_run_length !== w.run ||
                   rsp_is_dummy !== w.dummy || rsp_bad_char !== w.bad) begin
                  if (fault_count < 10)
                     $display("word mismatch: value %h/%h run %h/%h dummy %b/%b bad %b/%b",
                              w.value, rsp_grid_value, w.run, rsp_run_length,
                              w.dummy, rsp_is_dummy, w.bad, rsp_bad_char);
                  fault_count++;
               end
            end
         end
         if (req_valid && !req_stall) decode_byte(req_char_code);
         rsp_stall <= $urandom_range(99) < recv_stall_pct;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void push_byte(input logic [7:0] c);
      text_bytes.push_back(c);
      if (!is_space(c)) bytes_queued++;
   endfunction

   function automatic logic [7:0] any_space();
      case ($urandom_range(5))
         0:       return CHAR_SPACE;
         default: return 8'($urandom_range(CHAR_CR, CHAR_TAB));
      endcase
   endfunction

   // Lean towards the smallest and largest digits now and then.
   function automatic logic [7:0] any_digit();
      case ($urandom_range(9))
         0:       return DIGIT_BASE;
         1:       return DIGIT_TOP;
         default: return 8'($urandom_range(DIGIT_TOP, DIGIT_BASE));
      endcase
   endfunction

   function automatic logic [7:0] any_illegal();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (is_space(c) || c == CHAR_BANG || c == CHAR_QUOTE ||
             (c >= DIGIT_BASE && c <= DIGIT_TOP));
      return c;
   endfunction

   function automatic void push_digits(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) push_byte(any_space());
         push_byte(any_digit());
      end
   endfunction

   function automatic void push_special(input logic [7:0] c, input int n);
      for (int i = 0; i < n; i++) push_byte(c);
   endfunction

   // One random stretch of grid text: mostly well-formed groups, some noise.
   function automatic void push_random_stretch();
      int w;
      int k;
      int pick;
      w    = group_width();
      pick = $urandom_range(99);
      if (pick < 45) begin
         push_digits(w);
      end else if (pick < 55) begin
         push_special(CHAR_BANG, w);
      end else if (pick < 80) begin
         // repeat: code, run count, then the value
         push_special(CHAR_QUOTE, w);
         if ($urandom_range(9) == 0) push_special(DIGIT_BASE, w);
         else push_digits(w);
         case ($urandom_range(19))
            0:       push_special(CHAR_QUOTE, w);
            1, 2, 3: push_special(CHAR_BANG, w);
            default: push_digits(w);
         endcase
      end else if (pick < 88) begin
         push_digits($urandom_range(w - 1));
         push_byte(any_illegal());
      end else if (pick < 95 && w > 1) begin
         // open a group of one kind, break it with another
         k = $urandom_range(w - 1, 1);
         case ($urandom_range(2))
            0: begin
               push_special(CHAR_BANG, k);
               push_byte($urandom_range(1) ? CHAR_QUOTE : any_digit());
            end
            1: begin
               push_special(CHAR_QUOTE, k);
               push_byte($urandom_range(1) ? CHAR_BANG : any_digit());
            end
            default: begin
               push_digits(k);
               push_byte($urandom_range(1) ? CHAR_BANG : CHAR_QUOTE);
            end
         endcase
      end else begin
         repeat ($urandom_range(4, 1)) push_byte(any_space());
      end
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_DIGITS: digits_cfg = data[2:0];
         REG_SCALE:  scale_cfg  = data[23:0];
         REG_OFFSET: offset_cfg = data[47:0];
         REG_DUMMY:  dummy_cfg  = data[31:0];
         default: ;
      endcase
   endtask

   // Wait until every byte is taken and every word delivered, then let the
   // block finish any byte that owes no word.
   task automatic wait_idle();
      while (text_bytes.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [47:0] noise;
      logic [23:0] scale_v;
      logic [47:0] offset_v;
      logic [31:0] dummy_v;
      logic [2:0]  digits_v;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_char_code  = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fault_count    = 0;
      bytes_queued   = 0;
      digits_cfg     = RST_DIGITS;
      scale_cfg      = RST_SCALE;
      offset_cfg     = RST_OFFSET;
      dummy_cfg      = RST_DUMMY;
      repeat_phase   = PH_NORMAL;
      repeat_count   = '0;
      clear_group();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings (one digit per group):
      // smallest and largest digit, whitespace, dummy, repeat with a count,
      // zero count, special codes as count and as value, illegal bytes.
      push_byte(DIGIT_BASE);
      push_byte(DIGIT_TOP);
      push_byte(CHAR_TAB);
      push_byte(CHAR_CR);
      push_byte(CHAR_SPACE);
      push_byte(CHAR_BANG);
      push_byte(CHAR_QUOTE); push_byte(8'd40); push_byte(8'd65);
      push_byte(CHAR_QUOTE); push_byte(DIGIT_BASE); push_byte(DIGIT_TOP);
      push_byte(CHAR_QUOTE); push_byte(CHAR_BANG);
      push_byte(CHAR_QUOTE); push_byte(CHAR_QUOTE);
      push_byte(CHAR_QUOTE); push_byte(8'd53); push_byte(CHAR_BANG);
      push_byte(CHAR_QUOTE); push_byte(8'd53); push_byte(CHAR_QUOTE);
      push_byte(8'd0);
      push_byte(8'd255);
      push_byte(8'd35);
      push_byte(8'd127);
      wait_idle();

      // Three-digit groups at extreme scale and offset: mixed specials, largest raw.
      write_reg(REG_DIGITS, 48'd3);
      write_reg(REG_SCALE, 48'hFF_FFFF);
      write_reg(REG_OFFSET, 48'h7FFF_FFFF_FFFF);
      write_reg(REG_DUMMY, 48'h8000_0000);
      push_special(CHAR_BANG, 2); push_byte(8'd65);
      push_byte(8'd65); push_byte(8'd66); push_byte(CHAR_BANG);
      push_byte(CHAR_QUOTE); push_byte(CHAR_BANG);
      push_special(DIGIT_TOP, 3);
      wait_idle();

      // Narrow the group mid-way: the open group closes at its next byte.
      write_reg(REG_DIGITS, 48'd5);
      push_special(DIGIT_TOP, 2);
      wait_idle();
      write_reg(REG_DIGITS, 48'd1);
      push_byte(DIGIT_TOP);
      wait_idle();

      // Random phases: a new setting each, idling pattern rotating.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: digits_v = 3'd1;
            1: digits_v = 3'd5;
            2: digits_v = 3'd3;
            3: digits_v = 3'd0;
            4: digits_v = 3'd7;
            5: digits_v = 3'd2;
            6: digits_v = 3'd4;
            default: digits_v = 3'd6;
         endcase
         case (p)
            0: scale_v = 24'h01_0000;
            1: scale_v = 24'h80_0000;
            2: scale_v = 24'h7F_FFFF;
            4: scale_v = 24'h00_0000;
            6: scale_v = 24'hFF_FFFF;
            default: scale_v = 24'($urandom);
         endcase
         case (p)
            1: offset_v = 48'h7FFF_FFFF_FFFF;
            2: offset_v = 48'h8000_0000_0000;
            4: offset_v = 48'h0;
            default: offset_v = {16'($urandom), 32'($urandom)};
         endcase
         case (p)
            1: dummy_v = 32'h7FFF_FFFF;
            2: dummy_v = 32'h8000_0000;
            default: dummy_v = 32'($urandom);
         endcase
         // carry junk above each narrow register; the block keeps the low bits
         noise = {16'($urandom), 32'($urandom)};
         write_reg(REG_DIGITS, {noise[47:3], digits_v});
         write_reg(REG_SCALE, {noise[47:24], scale_v});
         write_reg(REG_OFFSET, offset_v);
         write_reg(REG_DUMMY, {noise[47:32], dummy_v});

         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase

         bytes_queued = 0;
         while (bytes_queued < 75) push_random_stretch();
         wait_idle();
      end

      if (fault_count == 0 && expected_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
